FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL of the keyed record table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define KRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define KRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/krt_pkg.sv
// Package of types, widths and codes for the keyed record table.
package krt_pkg;

	// Default table depth
	localparam int unsigned DEF_TABLE_DEPTH = 64;

	// Field widths
	localparam int unsigned REQ_W         = 2;
	localparam int unsigned KEY_W         = 34;
	localparam int unsigned RELAY_W       = 8;
	localparam int unsigned MINUTES_W     = 16;
	localparam int unsigned HIT_INDEX_W   = 6;
	localparam int unsigned STATUS_W      = 2;
	localparam int unsigned ENTRIES_W     = 7;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

	// One stored record
	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [RELAY_W-1:0]   relays;
		logic [MINUTES_W-1:0] minutes;
	} record_t;

endpackage

FILE: hdl/keyed_record_table_core.sv
// Keyed record table: unsorted record array with linear search and compacting remove.
//
// Usage: drive req_type, phone_key, relay_count and call_minutes and raise start;
// the item is taken at a rising edge where start is high and busy is low.
// busy stays high while the sequencer works on the item. The result appears on
// hit, hit_index, hit_relays, hit_minutes, status, entries, is_full_flag and
// is_empty_flag for exactly one cycle, marked by done; the receiver cannot stall,
// and a new item may be started in the same cycle that done is high.
// An insert, an unused code, or a search or remove on an empty table is handled
// in the idle state without a scan. A search compares the records in order from
// position 0 and stops at the first match or after the last record; a remove
// that hits then moves each later record down one place, and a remove miss
// ends after the last record. The pace is set by the record memory's single
// read port: one read for a compare or a move each cycle, with the read data
// registered and the 34-bit key compare done on it.
// Reset clears the record count and the sequencer; the record memory is not
// cleared, as only entries below the count are ever used.
`include "assert_macros.svh"

module keyed_record_table_core #(
	parameter int unsigned TABLE_DEPTH = krt_pkg::DEF_TABLE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [krt_pkg::REQ_W-1:0]         req_type,
	input  logic [krt_pkg::KEY_W-1:0]         phone_key,
	input  logic [krt_pkg::RELAY_W-1:0]       relay_count,
	input  logic [krt_pkg::MINUTES_W-1:0]     call_minutes,
	output logic                              done,
	output logic                              hit,
	output logic [krt_pkg::HIT_INDEX_W-1:0]   hit_index,
	output logic [krt_pkg::RELAY_W-1:0]       hit_relays,
	output logic [krt_pkg::MINUTES_W-1:0]     hit_minutes,
	output logic [krt_pkg::STATUS_W-1:0]      status,
	output logic [krt_pkg::ENTRIES_W-1:0]     entries,
	output logic                              is_full_flag,
	output logic                              is_empty_flag
);

	import krt_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned PTR_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       ptr_q;
	logic [REQ_W-1:0]       req_q;
	logic [KEY_W-1:0]       key_q;
	logic                   done_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       hidx_q;
	logic [RELAY_W-1:0]     hrel_q;
	logic [MINUTES_W-1:0]   hmin_q;
	logic [STATUS_W-1:0]    status_q;

	// Record memory, one write and one registered read per cycle
	record_t                mem [TABLE_DEPTH];
	record_t                rdata_q;
	record_t                wdata;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [IDX_W-1:0]       raddr;

	logic [PTR_W-1:0]       ptr_next;
	logic [PTR_W-1:0]       count_ext;
	logic                   scan_last;
	logic                   shift_more;
	logic                   insert_ok;

	assign ptr_next   = PTR_W'(ptr_q) + 1'b1;
	assign count_ext  = PTR_W'(count_q);
	assign scan_last  = (ptr_next == count_ext);
	assign shift_more = (ptr_next < count_ext);
	assign insert_ok  = (count_q != CNT_FULL);

	// Select the memory write: append on insert, move down during a remove
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rdata_q;
		case (state_q)
			S_IDLE: begin
				we    = start && (req_type == REQ_INSERT) && insert_ok;
				waddr = IDX_W'(count_q);
				wdata = '{key: phone_key, relays: relay_count, minutes: call_minutes};
			end
			S_SHIFT: begin
				we    = shift_more;
				waddr = ptr_q;
				wdata = rdata_q;
			end
			default: begin
				we    = 1'b0;
			end
		endcase
	end

	// Select the read address one entry ahead of the compare or move
	always_comb begin
		case (state_q)
			S_IDLE:  raddr = '0;
			S_SCAN:  raddr = IDX_W'(ptr_next);
			S_SHIFT: raddr = IDX_W'(PTR_W'(ptr_q) + PTR_W'(2));
			default: raddr = '0;
		endcase
	end

	// Write and read the record memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Sequence one item: append, scan, or scan and compact
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			req_q    <= REQ_INSERT;
			key_q    <= '0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			hidx_q   <= '0;
			hrel_q   <= '0;
			hmin_q   <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req_type;
						key_q    <= phone_key;
						ptr_q    <= '0;
						hit_q    <= 1'b0;
						hidx_q   <= '0;
						hrel_q   <= '0;
						hmin_q   <= '0;
						status_q <= ST_OK;
						case (req_type)
							REQ_INSERT: begin
								done_q <= 1'b1;
								if (insert_ok) begin
									count_q <= count_q + 1'b1;
								end else begin
									status_q <= ST_FULL;
								end
							end
							REQ_SEARCH, REQ_REMOVE: begin
								if (count_q == '0) begin
									status_q <= ST_MISS;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rdata_q.key == key_q) begin
						hit_q  <= 1'b1;
						hidx_q <= ptr_q;
						if (req_q == REQ_SEARCH) begin
							hrel_q  <= rdata_q.relays;
							hmin_q  <= rdata_q.minutes;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (scan_last) begin
						status_q <= ST_MISS;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						ptr_q <= IDX_W'(ptr_next);
					end
				end
				S_SHIFT: begin
					if (shift_more) begin
						ptr_q <= IDX_W'(ptr_next);
					end else begin
						count_q <= count_q - 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Drive the ports
	logic [HIT_INDEX_W+IDX_W-1:0] hidx_ext;
	logic [ENTRIES_W+CNT_W-1:0]   count_pad;

	assign hidx_ext  = {{HIT_INDEX_W{1'b0}}, hidx_q};
	assign count_pad = {{ENTRIES_W{1'b0}}, count_q};

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign hit           = hit_q;
	assign hit_index     = hidx_ext[HIT_INDEX_W-1:0];
	assign hit_relays    = hrel_q;
	assign hit_minutes   = hmin_q;
	assign status        = status_q;
	assign entries       = count_pad[ENTRIES_W-1:0];
	assign is_full_flag  = (count_q == CNT_FULL);
	assign is_empty_flag = (count_q == '0);

	// Checks on the sequencer and the record count
	`KRT_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`KRT_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`KRT_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == S_SCAN, count_ext > PTR_W'(ptr_q))
	`KRT_ASSERT_NEXT(a_insert_grows, clk, arst_n, start && !busy && req_type == REQ_INSERT && insert_ok, done_q && count_q == CNT_W'($past(count_q) + 1'b1))

endmodule

FILE: tb/tb.sv
// Testbench for keyed_record_table_core: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb;

	import krt_pkg::*;

	// Scoreboard: keeps its own copy of the record table and the expected outcomes
	class record_table_scoreboard;

		typedef struct {
			logic                   hit;
			logic [HIT_INDEX_W-1:0] hit_index;
			logic [RELAY_W-1:0]     hit_relays;
			logic [MINUTES_W-1:0]   hit_minutes;
			logic [STATUS_W-1:0]    status;
			logic [ENTRIES_W-1:0]   entries;
			logic                   is_full_flag;
			logic                   is_empty_flag;
		} outcome_t;

		logic [KEY_W-1:0]     keys    [DEF_TABLE_DEPTH];
		logic [RELAY_W-1:0]   relays  [DEF_TABLE_DEPTH];
		logic [MINUTES_W-1:0] minutes [DEF_TABLE_DEPTH];
		int unsigned          count;
		outcome_t             outcomes[$];
		int unsigned          errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return outcomes.size();
		endfunction

		function int unsigned size();
			return count;
		endfunction

		function logic [KEY_W-1:0] key_at(int unsigned idx);
			return keys[idx];
		endfunction

		// Apply one accepted item to the table copy and queue its outcome
		function void note_item(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
				logic [RELAY_W-1:0] rel, logic [MINUTES_W-1:0] mins);
			outcome_t    o;
			int unsigned pos;
			bit          found;
			o = '{default: '0};
			o.status = ST_OK;
			found = 0;
			pos = 0;
			if (req == REQ_SEARCH || req == REQ_REMOVE) begin
				for (int unsigned i = 0; i < count; i++) begin
					if (!found && keys[i] == key) begin
						found = 1;
						pos = i;
					end
				end
			end
			case (req)
				REQ_INSERT: begin
					if (count >= DEF_TABLE_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						keys[count]    = key;
						relays[count]  = rel;
						minutes[count] = mins;
						count++;
					end
				end
				REQ_SEARCH: begin
					if (found) begin
						o.hit         = 1'b1;
						o.hit_index   = pos[HIT_INDEX_W-1:0];
						o.hit_relays  = relays[pos];
						o.hit_minutes = minutes[pos];
					end else begin
						o.status = ST_MISS;
					end
				end
				REQ_REMOVE: begin
					if (found) begin
						o.hit       = 1'b1;
						o.hit_index = pos[HIT_INDEX_W-1:0];
						// Close the gap left by the removed record
						for (int unsigned i = pos; i + 1 < count; i++) begin
							keys[i]    = keys[i+1];
							relays[i]  = relays[i+1];
							minutes[i] = minutes[i+1];
						end
						count--;
					end else begin
						o.status = ST_MISS;
					end
				end
				default: begin
				end
			endcase
			o.entries       = count[ENTRIES_W-1:0];
			o.is_full_flag  = (count == DEF_TABLE_DEPTH);
			o.is_empty_flag = (count == 0);
			outcomes.push_back(o);
		endfunction

		function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one result with the oldest outcome
		function void check_result(logic hit, logic [HIT_INDEX_W-1:0] hit_index,
				logic [RELAY_W-1:0] hit_relays, logic [MINUTES_W-1:0] hit_minutes,
				logic [STATUS_W-1:0] status, logic [ENTRIES_W-1:0] entries,
				logic is_full_flag, logic is_empty_flag);
			outcome_t o;
			if (outcomes.size() == 0) begin
				$error("result with no item waiting");
				errors++;
				return;
			end
			o = outcomes.pop_front();
			compare_field("hit", 64'(o.hit), 64'(hit));
			compare_field("hit_index", 64'(o.hit_index), 64'(hit_index));
			compare_field("hit_relays", 64'(o.hit_relays), 64'(hit_relays));
			compare_field("hit_minutes", 64'(o.hit_minutes), 64'(hit_minutes));
			compare_field("status", 64'(o.status), 64'(status));
			compare_field("entries", 64'(o.entries), 64'(entries));
			compare_field("is_full_flag", 64'(o.is_full_flag), 64'(is_full_flag));
			compare_field("is_empty_flag", 64'(o.is_empty_flag), 64'(is_empty_flag));
		endfunction

	endclass

	localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
	localparam int unsigned RANDOM_ITEMS = 1700;
	localparam int unsigned POOL_SIZE   = 24;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX    = 34'd9999999999;
	localparam logic [KEY_W-1:0] KEY_ALT    = 34'h155555555;
	localparam logic [KEY_W-1:0] KEY_ABSENT = 34'd1234567890;

	// Phases of the random part
	localparam int PH_FILL  = 0;
	localparam int PH_DRAIN = 1;
	localparam int PH_MIXED = 2;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [REQ_W-1:0]       req_type;
	logic [KEY_W-1:0]       phone_key;
	logic [RELAY_W-1:0]     relay_count;
	logic [MINUTES_W-1:0]   call_minutes;
	logic                   done;
	logic                   hit;
	logic [HIT_INDEX_W-1:0] hit_index;
	logic [RELAY_W-1:0]     hit_relays;
	logic [MINUTES_W-1:0]   hit_minutes;
	logic [STATUS_W-1:0]    status;
	logic [ENTRIES_W-1:0]   entries;
	logic                   is_full_flag;
	logic                   is_empty_flag;

	record_table_scoreboard sb = new();
	logic [KEY_W-1:0]       key_pool[POOL_SIZE];
	int unsigned            random_sent;

	keyed_record_table_core #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.phone_key(phone_key),
		.relay_count(relay_count),
		.call_minutes(call_minutes),
		.done(done),
		.hit(hit),
		.hit_index(hit_index),
		.hit_relays(hit_relays),
		.hit_minutes(hit_minutes),
		.status(status),
		.entries(entries),
		.is_full_flag(is_full_flag),
		.is_empty_flag(is_empty_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result on the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(hit, hit_index, hit_relays, hit_minutes, status, entries,
				is_full_flag, is_empty_flag);
	end

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return KEY_W'(v % 64'd10000000000);
	endfunction

	// Present one item and hold it until taken; start stays high afterwards
	task automatic send_item(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
			input logic [RELAY_W-1:0] rel, input logic [MINUTES_W-1:0] mins);
		@(negedge clk);
		req_type     = req;
		phone_key    = key;
		relay_count  = rel;
		call_minutes = mins;
		start        = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(req, key, rel, mins);
	endtask

	// Drop start for a number of cycles
	task automatic hold_off(input int unsigned cycles);
		if (cycles == 0)
			return;
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every outcome has been checked
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Pick one operation and key for the given phase and send it
	task automatic send_random(input int phase);
		int unsigned      r;
		int unsigned      c;
		logic [REQ_W-1:0] req;
		logic [KEY_W-1:0] key;
		r = $urandom_range(0, 99);
		case (phase)
			PH_FILL:  req = (r < 75) ? REQ_INSERT : (r < 89) ? REQ_SEARCH :
				(r < 97) ? REQ_REMOVE : REQ_UNUSED;
			PH_DRAIN: req = (r < 15) ? REQ_INSERT : (r < 40) ? REQ_SEARCH :
				(r < 97) ? REQ_REMOVE : REQ_UNUSED;
			default:  req = (r < 40) ? REQ_INSERT : (r < 72) ? REQ_SEARCH :
				(r < 97) ? REQ_REMOVE : REQ_UNUSED;
		endcase
		c = $urandom_range(0, 99);
		if (req == REQ_INSERT) begin
			key = (c < 50) ? key_pool[$urandom_range(0, POOL_SIZE-1)] : rand_key();
		end else if (c < 60 && sb.size() > 0) begin
			key = sb.key_at($urandom_range(0, sb.size() - 1));
		end else if (c < 85) begin
			key = key_pool[$urandom_range(0, POOL_SIZE-1)];
		end else begin
			key = rand_key();
		end
		send_item(req, key, RELAY_W'($urandom_range(0, 255)),
			MINUTES_W'($urandom_range(0, 65535)));
	endtask

	initial begin
		int          phase;
		int unsigned phase_len;
		int unsigned burst_left;
		bit          first_phase;

		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_INSERT;
		phone_key    = '0;
		relay_count  = '0;
		call_minutes = '0;
		random_sent  = 0;

		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = rand_key();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, unused code, field extremes, duplicates, compaction
		send_item(REQ_SEARCH, '0, '0, '0);
		send_item(REQ_REMOVE, KEY_MAX, '0, '0);
		send_item(REQ_UNUSED, KEY_MAX, 8'hFF, 16'hFFFF);
		send_item(REQ_INSERT, '0, 8'h00, 16'h0000);
		send_item(REQ_INSERT, KEY_MAX, 8'hFF, 16'hFFFF);
		hold_off(3);
		send_item(REQ_INSERT, KEY_ALT, 8'hAA, 16'h5555);
		send_item(REQ_INSERT, '0, 8'h07, 16'd1234);
		send_item(REQ_SEARCH, '0, '0, '0);
		send_item(REQ_SEARCH, KEY_MAX, '0, '0);
		send_item(REQ_SEARCH, KEY_ABSENT, '0, '0);
		send_item(REQ_REMOVE, KEY_MAX, '0, '0);
		send_item(REQ_SEARCH, KEY_ALT, '0, '0);
		send_item(REQ_REMOVE, '0, '0, '0);
		send_item(REQ_SEARCH, '0, '0, '0);
		send_item(REQ_REMOVE, KEY_ABSENT, '0, '0);
		send_item(REQ_UNUSED, '0, '0, '0);
		send_item(REQ_REMOVE, '0, '0, '0);
		send_item(REQ_REMOVE, KEY_ALT, '0, '0);
		send_item(REQ_REMOVE, KEY_ALT, '0, '0);
		send_item(REQ_SEARCH, KEY_ALT, '0, '0);
		settle();

		// Random: phases that fill, drain or mix, sent in bursts with gaps
		first_phase = 1;
		burst_left  = $urandom_range(1, 20);
		while (random_sent < RANDOM_ITEMS) begin
			if (first_phase) begin
				phase = PH_FILL;
				phase_len = 150;
				first_phase = 0;
			end else begin
				phase = $urandom_range(PH_FILL, PH_MIXED);
				phase_len = $urandom_range(40, 150);
			end
			for (int unsigned n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
				send_random(phase);
				random_sent++;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					hold_off($urandom_range(0, 12));
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
						$urandom_range(1, 20);
				end
			end
			if ($urandom_range(0, 2) == 0)
				settle();
		end

		// Wait out the last results
		settle();
		repeat (DEPTH + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Timeout
	initial begin
		#8000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
